>>> rtl/utf8_pkg.sv
// Shared constants, types and lead byte decoding for the UTF-8 stream decoder.
`default_nettype none

package utf8_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CP_W       = 31;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned CONT_BITS  = 6;
   localparam int unsigned RSP_DATA_W = ((CP_W + LEN_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - CP_W - LEN_W;

   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;
   localparam logic [LEN_W-1:0] LEN_FIVE = 3'd5;
   localparam logic [LEN_W-1:0] LEN_SIX  = 3'd6;

   localparam logic [BYTE_W-1:0] MASK_ONE   = 8'h7f;
   localparam logic [BYTE_W-1:0] MASK_TWO   = 8'h1f;
   localparam logic [BYTE_W-1:0] MASK_THREE = 8'h0f;
   localparam logic [BYTE_W-1:0] MASK_FOUR  = 8'h07;
   localparam logic [BYTE_W-1:0] MASK_FIVE  = 8'h03;
   localparam logic [BYTE_W-1:0] MASK_SIX   = 8'h01;

   typedef struct packed {
      logic              err;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] payload;
   } lead_info_type;

   // Classifies a byte seen while no sequence is open.
   function automatic lead_info_type decode_lead(input logic [BYTE_W-1:0] b,
                                                 input logic allow_long);
      lead_info_type info;
      info.err     = 1'b0;
      info.len     = LEN_NONE;
      info.payload = '0;
      case (b) inside
         8'b0???_????: begin
            info.len = LEN_ONE;   info.payload = b & MASK_ONE;
         end
         8'b110?_????: begin
            info.len = LEN_TWO;   info.payload = b & MASK_TWO;
         end
         8'b1110_????: begin
            info.len = LEN_THREE; info.payload = b & MASK_THREE;
         end
         8'b1111_0???: begin
            info.len = LEN_FOUR;  info.payload = b & MASK_FOUR;
         end
         8'b1111_10??: begin
            info.len = LEN_FIVE;  info.payload = b & MASK_FIVE;
         end
         8'b1111_110?: begin
            info.len = LEN_SIX;   info.payload = b & MASK_SIX;
         end
         default: begin
            info.err = 1'b1;
         end
      endcase
      // Four to six byte forms are refused when the long forms are switched off.
      if (!allow_long && !info.err && info.len > LEN_THREE) begin
         info.err     = 1'b1;
         info.len     = LEN_NONE;
         info.payload = '0;
      end
      if (info.err) begin
         info.len     = LEN_NONE;
         info.payload = '0;
      end
      return info;
   endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder (original six byte form): input register, decode, result register.
// A result reaches rsp from req through the byte register and then the result register.
// Throughput: one byte per cycle; the single decode pass between the byte register
// and the result register sets this, and req only stalls while a result waits on rsp.
// Reset is synchronous and active high: both stages empty, no sequence open,
// and the long forms (four to six bytes) enabled.
`default_nettype none

module utf8_stream_decoder
   import utf8_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Register: allow_long_forms
   input  wire logic                  csr_wen,
   input  wire logic [0:0]            csr_wdata,   // [0] allow_long_forms
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] byte_in
   // Result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [30:0] code_point, [33:31] seq_length
   output logic [0:0]                 rsp_tuser    // [0] error
);

   logic              allow_long_ff;
   logic              byte_valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [CP_W-1:0]   acc_ff,  acc_in;
   logic [LEN_W-1:0]  rem_ff,  rem_in;
   logic [LEN_W-1:0]  slen_ff, slen_in;
   logic              rsp_valid_ff;
   logic [CP_W-1:0]   rsp_cp_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_err_ff;

   lead_info_type     lead;
   logic [CP_W-1:0]   acc_shift;
   logic [LEN_W-1:0]  rem_dec;
   logic              emit;
   logic [CP_W-1:0]   emit_cp;
   logic [LEN_W-1:0]  emit_len;
   logic              emit_err;
   logic              out_free;
   logic              advance;

   always_comb begin
      lead      = decode_lead(byte_ff, allow_long_ff);
      acc_shift = {acc_ff[CP_W-CONT_BITS-1:0], byte_ff[CONT_BITS-1:0]};
      rem_dec   = rem_ff - LEN_ONE;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      slen_in   = slen_ff;
      emit      = 1'b0;
      emit_cp   = '0;
      emit_len  = LEN_NONE;
      emit_err  = 1'b0;
      if (rem_ff != LEN_NONE) begin
         // Following byte: its low six bits are shifted in, the top bits are ignored.
         rem_in = rem_dec;
         if (rem_dec == LEN_NONE) begin
            emit     = 1'b1;
            emit_cp  = acc_shift;
            emit_len = slen_ff;
            acc_in   = '0;
            slen_in  = LEN_NONE;
         end else begin
            acc_in = acc_shift;
         end
      end else if (lead.err) begin
         emit     = 1'b1;
         emit_err = 1'b1;
         acc_in   = '0;
         slen_in  = LEN_NONE;
      end else if (lead.len == LEN_ONE) begin
         emit     = 1'b1;
         emit_cp  = CP_W'(lead.payload);
         emit_len = LEN_ONE;
      end else begin
         acc_in  = CP_W'(lead.payload);
         slen_in = lead.len;
         rem_in  = lead.len - LEN_ONE;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = byte_valid_ff && (!emit || out_free);
   assign req_tready = !byte_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_long_ff <= 1'b1;
         byte_valid_ff <= 1'b0;
         acc_ff        <= '0;
         rem_ff        <= LEN_NONE;
         slen_ff       <= LEN_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            allow_long_ff <= csr_wdata[0];
         end
         if (req_tready) begin
            byte_valid_ff <= req_tvalid;
         end
         if (advance) begin
            acc_ff  <= acc_in;
            rem_ff  <= rem_in;
            slen_ff <= slen_in;
         end
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata;
      end
      if (advance && emit) begin
         rsp_cp_ff  <= emit_cp;
         rsp_len_ff <= emit_len;
         rsp_err_ff <= emit_err;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{RSP_PAD_W{1'b0}}, rsp_len_ff, rsp_cp_ff};
   assign rsp_tuser[0] = rsp_err_ff;

   // An error result carries neither a code point nor a length.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_cp_ff == '0 && rsp_len_ff == LEN_NONE)
      else $error("error result with non-zero payload");

   // A good result has a length from one to six.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_err_ff |-> rsp_len_ff != LEN_NONE && rsp_len_ff <= LEN_SIX)
      else $error("good result with impossible length");

   // While a sequence is open, fewer bytes remain than its total length.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff != LEN_NONE |-> rem_ff < slen_ff && slen_ff >= LEN_TWO)
      else $error("sequence counters out of step");

   // A single byte result is plain ASCII.
   a_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_len_ff == LEN_ONE |-> rsp_cp_ff[CP_W-1:7] == '0)
      else $error("single byte result wider than seven bits");

   // A result that is not taken is not overwritten by the decode stage.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(advance && emit))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
